// File: rtl/ordered_channel_reorder_buffer_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ordered channel reorder buffer
// Shared concurrent assertion forms, clocked on clock, held off in reset.
// ----------------------------------------------------------------------------
`ifndef ORDERED_CHANNEL_REORDER_BUFFER_TOP_MACROS_SVH
`define ORDERED_CHANNEL_REORDER_BUFFER_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define OCRB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define OCRB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/ocrb_pkg.sv
// ----------------------------------------------------------------------------
// ocrb_pkg
// Types and fixed constants shared by the reorder buffer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ocrb_pkg;

   localparam int OFS_MAX_W = 6;   // window offset width for the largest window
   localparam int HALF_W    = 8;   // order number is split in two bytes for mod
   localparam int TAB_N     = 256; // entries per mod table
   localparam int QDEPTH    = 2;   // front to back queue depth
   localparam int RESULT_CAP = 32;

   typedef enum logic [1:0] {
      STAT_DELIVERED   = 2'd0,
      STAT_BUFFERED    = 2'd1,
      STAT_DROP_WINDOW = 2'd2,
      STAT_DROP_SYSTEM = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EVAL,
      ST_CHK,
      ST_LAST
   } state_type;

   typedef struct packed {
      logic [3:0]  channel;
      logic [15:0] order;
      logic [15:0] handle;
      logic [10:0] length;
      logic        is_sys;
   } req_type;

   typedef struct packed {
      logic [3:0]           channel;
      logic [15:0]          order;
      logic [15:0]          handle;
      logic [10:0]          length;
      logic                 is_sys;
      logic                 in_range;
      logic [OFS_MAX_W-1:0] ofs;       // order mod window
      logic [OFS_MAX_W-1:0] ofs_next;  // (order + 1) mod window
   } item_type;

   typedef struct packed {
      status_type  status;
      logic [3:0]  channel;
      logic [15:0] order;
      logic [15:0] handle;
      logic [10:0] length;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] order;
      logic [15:0] handle;
      logic [10:0] length;
   } slot_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_status_type;

endpackage

// File: rtl/ordered_channel_reorder_buffer_top.sv
// Ordered channel reorder buffer.
// req_* takes one decoded packet descriptor per item: channel, 16-bit order
// number, payload handle and length, and the system flag in req_tuser.
// rsp_* returns one item per reported packet: status in rsp_tuser, the
// packet fields in rsp_tdata, and rsp_tlast on the final item caused by one
// request. An in-order packet is delivered, then parked successors follow in
// ascending order, up to 31 of them; a packet 1 to WINDOW-1 ahead is parked,
// anything else is dropped with a status.
// Sequence: a parked or dropped packet is reported from the EVAL state, an
// in-order one from the CHK state, both through the result register.
// Each request takes the expected-order RAM lookup and evaluation; a drain
// adds a slot RAM read per delivered successor plus the final slot check.
// A 2-entry queue takes requests while the sequencer works or the result
// register waits; when rsp_tready is low the sequencer holds and the queue
// fills, then req_tready drops.
// Reset: a clearing pass over all CHANNELS*WINDOW slots (512 by default)
// zeroes the expected numbers and slot valid bits; req_tready is low meanwhile.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_channel_reorder_buffer_top
// Top level: stream ports, front classifier and queue, back sequencer.
// ----------------------------------------------------------------------------

module ordered_channel_reorder_buffer_top
   import ocrb_pkg::*;
#(
   parameter int CHANNELS = 16,
   parameter int WINDOW   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // channel_num, order_number, payload_handle,
                                    // payload_length, zero pad
   input  logic [0:0]  req_tuser,   // is_system
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // out_channel, out_order, out_handle,
                                    // out_length, zero pad
   output logic [1:0]  rsp_tuser,   // status
   output logic        rsp_tlast    // last_of_run
);

   req_type         req;
   back_status_type bstat;
   logic            q_valid;
   item_type        q_item;
   rsp_type         rsp;

   assign req.channel = req_tdata[3:0];
   assign req.order   = req_tdata[19:4];
   assign req.handle  = req_tdata[35:20];
   assign req.length  = req_tdata[46:36];
   assign req.is_sys  = req_tuser[0];

   ocrb_front #(.CHANNELS(CHANNELS), .WINDOW(WINDOW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .bstat     (bstat),
      .q_valid   (q_valid),
      .q_item    (q_item)
   );

   ocrb_back #(.CHANNELS(CHANNELS), .WINDOW(WINDOW)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .bstat     (bstat),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {1'b0, rsp.length, rsp.handle, rsp.order, rsp.channel};
   assign rsp_tuser = rsp.status;
   assign rsp_tlast = rsp.last;

endmodule

// File: rtl/ocrb_ram.sv
// ----------------------------------------------------------------------------
// ocrb_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ocrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ocrb_front.sv
// ----------------------------------------------------------------------------
// ocrb_front
// Accepts descriptors, classifies them, computes window offsets, and queues
// them for the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ordered_channel_reorder_buffer_top_macros.svh"

module ocrb_front
   import ocrb_pkg::*;
#(
   parameter int CHANNELS = 16,
   parameter int WINDOW   = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_type         req,
   input  back_status_type bstat,
   output logic            q_valid,
   output item_type        q_item
);

   localparam int OFS_W = $clog2(WINDOW);

   // order mod window = (hi * 256 mod W + lo mod W), one correction
   logic [OFS_W-1:0] hi_tab [TAB_N];
   logic [OFS_W-1:0] lo_tab [TAB_N];

   for (genvar gi = 0; gi < TAB_N; gi++) begin : g_tab
      assign hi_tab[gi] = OFS_W'((gi * TAB_N) % WINDOW);
      assign lo_tab[gi] = OFS_W'(gi % WINDOW);
   end

   logic [OFS_W:0]   mod_sum;
   logic [OFS_W-1:0] mod_r;
   logic [OFS_W-1:0] mod_next;
   item_type         entry;

   assign mod_sum = {1'b0, hi_tab[req.order[15:HALF_W]]} + {1'b0, lo_tab[req.order[HALF_W-1:0]]};
   assign mod_r   = (mod_sum >= (OFS_W+1)'(WINDOW)) ? OFS_W'(mod_sum - (OFS_W+1)'(WINDOW))
                                                    : OFS_W'(mod_sum);
   // wrap of the order number restarts the offset at zero
   assign mod_next = ((req.order == 16'hFFFF) || (mod_r == OFS_W'(WINDOW - 1)))
                     ? '0 : mod_r + 1'b1;

   always_comb begin
      entry          = '0;
      entry.channel  = req.channel;
      entry.order    = req.order;
      entry.handle   = req.handle;
      entry.length   = req.length;
      entry.is_sys   = req.is_sys;
      entry.in_range = (32'(req.channel) < 32'(CHANNELS));
      entry.ofs      = OFS_MAX_W'(mod_r);
      entry.ofs_next = OFS_MAX_W'(mod_next);
   end

   // two entry queue
   item_type   q_mem_ff [QDEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign req_ready = (cnt_ff != 2'(QDEPTH)) && !bstat.clearing;
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = bstat.pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(bstat.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= entry;
      end
   end

   `OCRB_ASSERT_NOW(a_pop_nonempty, bstat.pop, cnt_ff != 2'd0, "queue popped while empty")

endmodule

// File: rtl/ocrb_back.sv
// ----------------------------------------------------------------------------
// ocrb_back
// Sequencer: looks up the expected order, parks, delivers or drops, drains the
// window, and holds the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ordered_channel_reorder_buffer_top_macros.svh"

module ocrb_back
   import ocrb_pkg::*;
#(
   parameter int CHANNELS = 16,
   parameter int WINDOW   = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   input  item_type        q_item,
   output back_status_type bstat,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_type         rsp
);

   localparam int OFS_W      = $clog2(WINDOW);
   localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SLOT_DEPTH = CHANNELS * WINDOW;
   localparam int SLOT_AW    = $clog2(SLOT_DEPTH);
   localparam int LIMIT      = (WINDOW - 1 < RESULT_CAP - 1) ? WINDOW - 1 : RESULT_CAP - 1;
   localparam int CNT_W      = $clog2(LIMIT + 1);

   function automatic logic [SLOT_AW-1:0] slot_addr(input logic [CH_W-1:0] ch,
                                                    input logic [OFS_W-1:0] ofs);
      slot_addr = SLOT_AW'(int'(ch) * WINDOW + int'(ofs));
   endfunction

   state_type        state_ff, state_in;
   logic [SLOT_AW-1:0] clr_ff, clr_in;
   item_type         cur_ff, cur_in;
   logic [15:0]      exp_ff, exp_in;
   logic [OFS_W-1:0] emod_ff, emod_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   rsp_type          pend_ff, pend_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff;

   // RAM ports
   logic             exp_wr_en, exp_rd_en;
   logic [CH_W-1:0]  exp_wr_addr, exp_rd_addr;
   logic [15:0]      exp_wr_data, exp_rd_data;
   logic             slot_wr_en, slot_rd_en;
   logic [SLOT_AW-1:0] slot_wr_addr, slot_rd_addr;
   slot_type         slot_wr_data, slot_rd_data;

   logic             out_free;
   logic             emit;
   logic             clr_done;
   logic [15:0]      ahead;
   logic             hit;
   logic             cnt_end;
   logic [CH_W-1:0]  cur_idx;
   logic [OFS_W-1:0] emod_step;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign clr_done  = (clr_ff == SLOT_AW'(SLOT_DEPTH - 1));
   assign cur_idx   = CH_W'(cur_ff.channel);
   assign ahead     = cur_ff.order - exp_rd_data;
   assign hit       = slot_rd_data.valid && (slot_rd_data.order == exp_ff);
   assign cnt_end   = (cnt_ff == CNT_W'(LIMIT - 1));
   assign emod_step = ((exp_ff == 16'hFFFF) || (emod_ff == OFS_W'(WINDOW - 1)))
                      ? '0 : emod_ff + 1'b1;

   ocrb_ram #(.WIDTH(16), .DEPTH(CHANNELS)) u_exp_ram (
      .clock   (clock),
      .wr_en   (exp_wr_en),
      .wr_addr (exp_wr_addr),
      .wr_data (exp_wr_data),
      .rd_en   (exp_rd_en),
      .rd_addr (exp_rd_addr),
      .rd_data (exp_rd_data)
   );

   ocrb_ram #(.WIDTH($bits(slot_type)), .DEPTH(SLOT_DEPTH)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (q_valid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (!cur_ff.is_sys && cur_ff.in_range && (ahead == 16'd0)) begin
               state_in = ST_CHK;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_CHK: begin
            if (out_free) begin
               if (!hit) state_in = ST_IDLE;
               else if (cnt_end) state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      exp_in       = exp_ff;
      emod_in      = emod_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      emit         = 1'b0;
      bstat.pop    = 1'b0;
      bstat.clearing = (state_ff == ST_CLEAR);
      exp_wr_en    = 1'b0;
      exp_wr_addr  = cur_idx;
      exp_wr_data  = cur_ff.order + 16'd1;
      exp_rd_en    = 1'b0;
      exp_rd_addr  = CH_W'(q_item.channel);
      slot_wr_en   = 1'b0;
      slot_wr_addr = slot_addr(cur_idx, OFS_W'(cur_ff.ofs));
      slot_wr_data = '0;
      slot_rd_en   = 1'b0;
      slot_rd_addr = slot_addr(CH_W'(q_item.channel), OFS_W'(q_item.ofs_next));

      case (state_ff)
         ST_CLEAR: begin
            slot_wr_en   = 1'b1;
            slot_wr_addr = clr_ff;
            exp_wr_en    = (32'(clr_ff) < 32'(CHANNELS));
            exp_wr_addr  = CH_W'(clr_ff);
            exp_wr_data  = 16'd0;
            clr_in       = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (q_valid) begin
               bstat.pop  = 1'b1;
               cur_in     = q_item;
               // the successor slot is read up front for the in-order case
               exp_rd_en  = q_item.in_range;
               slot_rd_en = q_item.in_range;
            end
         end
         ST_EVAL: begin
            rsp_in.channel = cur_ff.channel;
            rsp_in.order   = cur_ff.order;
            rsp_in.handle  = cur_ff.handle;
            rsp_in.length  = cur_ff.length;
            rsp_in.last    = 1'b1;
            if (cur_ff.is_sys) begin
               rsp_in.status = STAT_DROP_SYSTEM;
               emit          = out_free;
            end else if (!cur_ff.in_range) begin
               rsp_in.status = STAT_DROP_WINDOW;
               emit          = out_free;
            end else if (ahead != 16'd0) begin
               emit = out_free;
               if (32'(ahead) < 32'(WINDOW)) begin
                  rsp_in.status       = STAT_BUFFERED;
                  slot_wr_en          = out_free;
                  slot_wr_data.valid  = 1'b1;
                  slot_wr_data.order  = cur_ff.order;
                  slot_wr_data.handle = cur_ff.handle;
                  slot_wr_data.length = cur_ff.length;
               end else begin
                  rsp_in.status = STAT_DROP_WINDOW;
               end
            end else begin
               pend_in        = rsp_in;
               pend_in.status = STAT_DELIVERED;
               exp_wr_en      = 1'b1;
               exp_in         = cur_ff.order + 16'd1;
               emod_in        = OFS_W'(cur_ff.ofs_next);
               cnt_in         = '0;
            end
         end
         ST_CHK: begin
            rsp_in       = pend_ff;
            slot_wr_addr = slot_addr(cur_idx, emod_ff);
            if (out_free) begin
               emit = 1'b1;
               if (hit) begin
                  rsp_in.last    = 1'b0;
                  pend_in.order  = exp_ff;
                  pend_in.handle = slot_rd_data.handle;
                  pend_in.length = slot_rd_data.length;
                  slot_wr_en     = 1'b1;
                  exp_wr_en      = 1'b1;
                  exp_wr_data    = exp_ff + 16'd1;
                  exp_in         = exp_ff + 16'd1;
                  emod_in        = emod_step;
                  cnt_in         = cnt_ff + 1'b1;
                  slot_rd_en     = !cnt_end;
                  slot_rd_addr   = slot_addr(cur_idx, emod_step);
               end else begin
                  // a slot holding a passed-over packet is dropped as well
                  rsp_in.last = 1'b1;
                  slot_wr_en  = slot_rd_data.valid;
               end
            end
         end
         ST_LAST: begin
            rsp_in      = pend_ff;
            rsp_in.last = 1'b1;
            emit        = out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      exp_ff  <= exp_in;
      emod_ff <= emod_in;
      cnt_ff  <= cnt_in;
      pend_ff <= pend_in;
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `OCRB_ASSERT_NOW(a_no_pop_clear, state_ff == ST_CLEAR, !bstat.pop, "item taken during clear")
   `OCRB_ASSERT_NOW(a_emit_free, emit, out_free, "result register overwritten")
   `OCRB_ASSERT_NOW(a_drain_bound, state_ff == ST_CHK, cnt_ff < CNT_W'(LIMIT), "drain overrun")
   `OCRB_ASSERT_NEXT(a_clear_done, (state_ff == ST_CLEAR) && clr_done, state_ff == ST_IDLE,
                     "clear pass did not end")

endmodule

// File: bench/ordered_channel_reorder_buffer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_channel_reorder_buffer_top_tb
// Drives packet descriptors into the reorder buffer and scores every result
// item against a cycle-free model of per-channel ordering: a directed table
// first, then shuffled runs of consecutive orders, full-window drains and
// noise, with random stalls on both streams.
// ----------------------------------------------------------------------------

module ordered_channel_reorder_buffer_top_tb;
   import ocrb_pkg::*;

   localparam int CHANNELS      = 16;
   localparam int WINDOW        = 32;
   localparam int RESET_CYCLES  = 12;
   localparam int ITEM_TARGET   = 410;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 4000000;

   typedef struct {
      req_type    pkt;
      bit         typed;   // status below is the known answer for this row
      status_type want;
   } stim_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;   // channel, order, handle, length, zero pad
   logic [0:0]  req_tuser  = '0;   // is_system
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // channel, order, handle, length, zero pad
   logic [1:0]  rsp_tuser;         // status
   logic        rsp_tlast;

   // ordering model state
   logic [15:0] next_order   [CHANNELS];
   bit          parked_valid [CHANNELS*WINDOW];
   req_type     parked_pkt   [CHANNELS*WINDOW];
   rsp_type     pending_reports [$];

   int error_count = 0;
   int items_sent  = 0;
   int cycle_count = 0;
   int stall_left  = 0;
   bit rsp_steady  = 1'b0;
   bit hold_req    = 1'b0;
   bit hold_done   = 1'b0;

   stim_row_type directed_rows [21] = '{
      '{'{4'd0,  16'd0,     16'h0000, 11'd0,    1'b0}, 1'b1, STAT_DELIVERED},
      '{'{4'd15, 16'd0,     16'hffff, 11'h7ff,  1'b0}, 1'b1, STAT_DELIVERED},
      '{'{4'd0,  16'd1,     16'h1234, 11'd100,  1'b1}, 1'b1, STAT_DROP_SYSTEM},
      '{'{4'd3,  16'hffff,  16'h0001, 11'd1,    1'b0}, 1'b1, STAT_DROP_WINDOW},
      '{'{4'd3,  16'd32,    16'h0032, 11'd32,   1'b0}, 1'b1, STAT_DROP_WINDOW},
      '{'{4'd3,  16'd31,    16'h0031, 11'd31,   1'b0}, 1'b1, STAT_BUFFERED},
      '{'{4'd3,  16'd1,     16'h0301, 11'd301,  1'b0}, 1'b1, STAT_BUFFERED},
      '{'{4'd3,  16'd2,     16'haaaa, 11'h2aa,  1'b0}, 1'b1, STAT_BUFFERED},
      '{'{4'd3,  16'd2,     16'h5555, 11'h555,  1'b0}, 1'b1, STAT_BUFFERED},
      '{'{4'd3,  16'd0,     16'h0300, 11'd300,  1'b0}, 1'b0, STAT_DELIVERED},
      '{'{4'd3,  16'd1,     16'h0bad, 11'd7,    1'b0}, 1'b1, STAT_DROP_WINDOW},
      '{'{4'd3,  16'd4,     16'h0304, 11'd304,  1'b0}, 1'b1, STAT_BUFFERED},
      '{'{4'd3,  16'd3,     16'h0303, 11'd303,  1'b0}, 1'b0, STAT_DELIVERED},
      '{'{4'd0,  16'd1,     16'h0001, 11'd1,    1'b0}, 1'b1, STAT_DELIVERED},
      '{'{4'd0,  16'd1,     16'h0002, 11'd2,    1'b0}, 1'b1, STAT_DROP_WINDOW},
      '{'{4'd15, 16'd1,     16'h7fff, 11'h400,  1'b1}, 1'b1, STAT_DROP_SYSTEM},
      '{'{4'd15, 16'd1,     16'h8000, 11'h3ff,  1'b0}, 1'b1, STAT_DELIVERED},
      '{'{4'd7,  16'd5,     16'h0705, 11'd705,  1'b0}, 1'b1, STAT_BUFFERED},
      '{'{4'd7,  16'd2,     16'h0702, 11'd702,  1'b0}, 1'b1, STAT_BUFFERED},
      '{'{4'd7,  16'd1,     16'h0701, 11'd701,  1'b0}, 1'b1, STAT_BUFFERED},
      '{'{4'd7,  16'd0,     16'h0700, 11'd700,  1'b0}, 1'b0, STAT_DELIVERED}
   };

   ordered_channel_reorder_buffer_top #(
      .CHANNELS (CHANNELS),
      .WINDOW   (WINDOW)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      foreach (next_order[c]) next_order[c] = '0;
      foreach (parked_valid[s]) parked_valid[s] = 1'b0;
   end

   // Works out the result items one accepted packet causes; keep = 0 only
   // advances the ordering state.
   function automatic void predict_reports(input req_type pkt, input bit keep);
      rsp_type     run [$];
      rsp_type     rep;
      logic [15:0] ahead;
      logic [15:0] want;
      int          ch;
      int          slot;
      int          limit;
      int          n;
      ch          = int'(pkt.channel);
      rep.status  = STAT_DELIVERED;
      rep.channel = pkt.channel;
      rep.order   = pkt.order;
      rep.handle  = pkt.handle;
      rep.length  = pkt.length;
      rep.last    = 1'b0;
      if (pkt.is_sys) begin
         rep.status = STAT_DROP_SYSTEM;
         run = {run, rep};
      end else if (ch >= CHANNELS) begin
         rep.status = STAT_DROP_WINDOW;
         run = {run, rep};
      end else begin
         ahead = pkt.order - next_order[ch];
         if (ahead != 16'd0) begin
            if (int'(ahead) < WINDOW) begin
               slot               = ch * WINDOW + int'(pkt.order) % WINDOW;
               parked_valid[slot] = 1'b1;
               parked_pkt[slot]   = pkt;
               rep.status         = STAT_BUFFERED;
            end else begin
               rep.status = STAT_DROP_WINDOW;
            end
            run = {run, rep};
         end else begin
            run = {run, rep};
            next_order[ch] = next_order[ch] + 16'd1;
            limit = WINDOW - 1;
            if (limit > RESULT_CAP - 1) limit = RESULT_CAP - 1;
            n = 0;
            while (n < limit) begin
               want = next_order[ch];
               slot = ch * WINDOW + int'(want) % WINDOW;
               if (!parked_valid[slot]) break;
               parked_valid[slot] = 1'b0;
               // a parked packet that was passed over is dropped silently
               if (parked_pkt[slot].order != want) break;
               rep.order      = want;
               rep.handle     = parked_pkt[slot].handle;
               rep.length     = parked_pkt[slot].length;
               run = {run, rep};
               next_order[ch] = want + 16'd1;
               n++;
            end
         end
      end
      run[run.size() - 1].last = 1'b1;
      if (keep) begin
         pending_reports = {pending_reports, run};
      end
   endfunction

   function automatic int pick_gap(input bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_packet(input req_type pkt, input bit quiet, input bit typed,
                              input status_type typed_status);
      int      gap;
      rsp_type rep;
      gap = pick_gap(quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, pkt.length, pkt.handle, pkt.order, pkt.channel};
      req_tuser  <= pkt.is_sys;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_reports(pkt, !typed);
      if (typed) begin
         rep.status  = typed_status;
         rep.channel = pkt.channel;
         rep.order   = pkt.order;
         rep.handle  = pkt.handle;
         rep.length  = pkt.length;
         rep.last    = 1'b1;
         pending_reports = {pending_reports, rep};
      end
      items_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   task automatic run_random_traffic();
      logic [15:0] orders [WINDOW];
      logic [15:0] tmp;
      req_type     pkt;
      int          ch;
      int          n;
      int          m;
      int          i;
      int          j;
      int          r;
      bit          quiet;
      bit          noisy;
      bit          paused;
      bit          first;
      paused = 1'b0;
      first  = 1'b1;
      while (items_sent < ITEM_TARGET) begin
         if (!paused && items_sent > ITEM_TARGET / 2) begin
            paused = 1'b1;
            wait_drained();
         end
         quiet = ($urandom_range(0, 3) == 0);
         noisy = 1'b0;
         ch    = $urandom_range(0, CHANNELS - 1);
         r     = first ? 0 : $urandom_range(0, 99);
         if (r < 5) begin
            // whole window parked out of order, then the in-order item drains it
            if (first) hold_req <= 1'b1;
            first = 1'b0;
            n     = WINDOW;
            m     = WINDOW - 1;
            for (i = 0; i < WINDOW - 1; i++) orders[i] = next_order[ch] + 16'(i + 1);
            orders[WINDOW - 1] = next_order[ch];
         end else if (r < 82) begin
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, WINDOW - 1)
                                            : $urandom_range(1, 8);
            m = n;
            for (i = 0; i < n; i++) orders[i] = next_order[ch] + 16'(i);
         end else begin
            noisy = 1'b1;
            n     = $urandom_range(1, 3);
            m     = 0;
         end
         for (i = m - 1; i > 0; i--) begin
            j         = $urandom_range(0, i);
            tmp       = orders[i];
            orders[i] = orders[j];
            orders[j] = tmp;
         end
         for (i = 0; i < n; i++) begin
            pkt.channel = 4'(ch);
            pkt.handle  = 16'($urandom_range(0, 65535));
            pkt.length  = 11'($urandom_range(0, 2047));
            pkt.is_sys  = 1'b0;
            if (noisy) begin
               pkt.channel = 4'($urandom_range(0, CHANNELS - 1));
               if ($urandom_range(0, 1) == 0) begin
                  pkt.order = 16'($urandom_range(0, 65535));
               end else begin
                  pkt.order = next_order[pkt.channel] + 16'($urandom_range(0, 40)) - 16'd4;
               end
               pkt.is_sys = ($urandom_range(0, 2) == 0);
            end else begin
               pkt.order = orders[i];
            end
            send_packet(pkt, quiet, 1'b0, STAT_DELIVERED);
            // occasional resend: slot replacement, stale drop or system copy
            if (!noisy && $urandom_range(0, 9) == 0) begin
               pkt.handle = 16'($urandom_range(0, 65535));
               pkt.is_sys = ($urandom_range(0, 3) == 0);
               send_packet(pkt, quiet, 1'b0, STAT_DELIVERED);
            end
         end
      end
   endtask

   function automatic void compare_field(input string name, input int unsigned want,
                                         input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   task automatic check_report();
      rsp_type want;
      if (pending_reports.size() == 0) begin
         $display("%0t: result item with none expected, actual ch %0h order %0h status %0d",
                  $time, rsp_tdata[3:0], rsp_tdata[19:4], rsp_tuser);
         error_count++;
      end else begin
         want = pending_reports.pop_front();
         compare_field("status",  want.status,  rsp_tuser);
         compare_field("channel", want.channel, rsp_tdata[3:0]);
         compare_field("order",   want.order,   rsp_tdata[19:4]);
         compare_field("handle",  want.handle,  rsp_tdata[35:20]);
         compare_field("length",  want.length,  rsp_tdata[46:36]);
         compare_field("last",    want.last,    rsp_tlast);
      end
   endtask

   always @(posedge clock) begin : rsp_side
      int r;
      if (!reset && rsp_tvalid && rsp_tready) check_report();
      if ($urandom_range(0, 149) == 0) rsp_steady <= !rsp_steady;
      if (hold_req && !hold_done) begin
         hold_done  <= 1'b1;
         stall_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_steady) begin
         rsp_tready <= 1'b1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 75) begin
            rsp_tready <= 1'b1;
         end else if (r < 96) begin
            rsp_tready <= 1'b0;
            stall_left <= $urandom_range(0, 2);
         end else begin
            rsp_tready <= 1'b0;
            stall_left <= $urandom_range(8, 30);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d result items outstanding", $time,
                  pending_reports.size());
         $display("[ordered_channel_reorder_buffer_top] ERROR");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[k]) begin
         send_packet(directed_rows[k].pkt, 1'b0, directed_rows[k].typed,
                     directed_rows[k].want);
      end
      wait_drained();
      run_random_traffic();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[ordered_channel_reorder_buffer_top] OK");
      end else begin
         $display("[ordered_channel_reorder_buffer_top] ERROR");
      end
      $finish;
   end

endmodule
